@@ rtl/core/pacc_pkg.sv @@
// Shared types and codes for the point accumulator with its undo stack.
`default_nettype none

package pacc_pkg;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_NEG  = 2'd1,
    CMD_CMP  = 2'd2,
    CMD_UNDO = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  localparam int CoordWidth = 32;

endpackage

`default_nettype wire

@@ rtl/core/pacc_if.sv @@
// Valid/ready channel interfaces for command beats and result beats.
`default_nettype none

interface pacc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic signed [31:0] dx;
  logic signed [31:0] dy;

  modport source (output valid, output command, output dx, output dy, input ready);
  modport sink   (input valid, input command, input dx, input dy, output ready);
endinterface

interface pacc_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic        equal;
  logic [1:0]  status;

  modport source (output valid, output point_x, output point_y, output equal,
                  output status, input ready);
  modport sink   (input valid, input point_x, input point_y, input equal,
                  input status, output ready);
endinterface

`default_nettype wire

@@ rtl/core/point_accumulator_with_undo_stack.sv @@
// Point accumulator: current 2D point plus a bounded LIFO history in one memory.
//
// Usage:
//   req carries command beats (command, dx, dy); rsp returns one result beat
//   per command (point_x, point_y, equal, status). Both are valid/ready.
//   Each command is accepted and then executed: the accept cycle issues a read
//   of the top of the history memory, and the execute step then applies the
//   command, pushes the old point if needed and loads the result register.
//   Because the history memory read is registered, a new command is not taken
//   until the execute step of the previous command has finished.
//   The result register decouples the sides: a command is accepted while the
//   previous result still waits on rsp. If the receiver stalls, the block
//   finishes the read and then holds in the execute step until the result
//   register frees, and req.ready stays low until then.
//   Reset clears the current point to zero, empties the stack and drops any
//   pending result. The history memory is not cleared; only entries below
//   the fill count are ever read back.
`default_nettype none

module point_accumulator_with_undo_stack
  import pacc_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  pacc_req_if.sink    req,
  pacc_rsp_if.source  rsp
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FillMax = CW'(STACK_DEPTH);

  state_t state, state_next;

  logic [CoordWidth-1:0] cur_x, cur_y, cur_x_next, cur_y_next;
  logic [CW-1:0]         fill, fill_next;

  logic [1:0]            op_cmd;
  logic [CoordWidth-1:0] op_dx, op_dy;

  logic [2*CoordWidth-1:0] mem [STACK_DEPTH];
  logic [2*CoordWidth-1:0] rd_data;
  logic [AW-1:0]           rd_addr;

  logic    accept, out_free, commit, push, eq_next;
  status_t status_next;

  assign accept   = req.valid && req.ready;
  assign out_free = !rsp.valid || rsp.ready;
  assign rd_addr  = fill[AW-1:0] - AW'(1);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready   = (state == S_IDLE);
    commit      = (state == S_EXEC) && out_free;
    cur_x_next  = cur_x;
    cur_y_next  = cur_y;
    fill_next   = fill;
    push        = 1'b0;
    eq_next     = 1'b0;
    status_next = ST_OK;
    case (cmd_t'(op_cmd))
      CMD_ADD: begin
        push        = (fill != FillMax);
        status_next = push ? ST_OK : ST_FULL;
        cur_x_next  = cur_x + op_dx;
        cur_y_next  = cur_y + op_dy;
      end
      CMD_NEG: begin
        push        = (fill != FillMax);
        status_next = push ? ST_OK : ST_FULL;
        cur_x_next  = '0 - cur_x;
        cur_y_next  = '0 - cur_y;
      end
      CMD_CMP: begin
        eq_next = (cur_x == op_dx) && (cur_y == op_dy);
      end
      CMD_UNDO: begin
        if (fill == '0) begin
          status_next = ST_EMPTY;
        end else begin
          fill_next  = fill - CW'(1);
          cur_x_next = rd_data[CoordWidth-1:0];
          cur_y_next = rd_data[2*CoordWidth-1:CoordWidth];
        end
      end
      default: status_next = ST_OK;
    endcase
    if (push) begin
      fill_next = fill + CW'(1);
    end
  end

  // The push writes at the commit edge; the next read can only follow at a
  // later accept edge, so the stack needs no forwarding path.
  always_ff @(posedge clk) begin
    if (commit && push) begin
      mem[fill[AW-1:0]] <= {cur_y, cur_x};
    end
    if (accept) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd <= req.command;
      op_dx  <= req.dx;
      op_dy  <= req.dy;
    end
    if (commit) begin
      rsp.point_x <= cur_x_next;
      rsp.point_y <= cur_y_next;
      rsp.equal   <= eq_next;
      rsp.status  <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_x     <= '0;
      cur_y     <= '0;
      fill      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        cur_x     <= cur_x_next;
        cur_y     <= cur_y_next;
        fill      <= fill_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pacc_checker.sv @@
// Port-level assertions for the point accumulator and their bind to the top level.
`default_nettype none

module pacc_checker
  import pacc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] point_x,
  input logic [31:0] point_y,
  input logic        equal,
  input logic [1:0]  status
);

  // A stalled result beat keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(point_x) && $stable(point_y)
      && $stable(equal) && $stable(status))
    else $error("result beat changed while stalled");

  // One command is in flight at a time, so ready drops after each accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("command accepted while another is executing");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_OK || status == ST_FULL || status == ST_EMPTY))
    else $error("undefined status code");

  // Only a compare reports equality, and a compare always finishes ok.
  a_equal_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && equal |-> status == ST_OK)
    else $error("equal flag with non-ok status");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result beat valid after reset");

endmodule

bind point_accumulator_with_undo_stack pacc_checker u_pacc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .point_x   (rsp.point_x),
  .point_y   (rsp.point_y),
  .equal     (rsp.equal),
  .status    (rsp.status)
);

`default_nettype wire
